@@ sv/bfifo_pkg.sv @@
package bfifo_pkg;

	localparam int DEPTH_DEF     = 1024;
	localparam int MAX_BURST_DEF = 16;

	localparam int OP_W     = 3;
	localparam int DATA_W   = 8;
	localparam int CNT_W    = 5;
	localparam int USED_W   = 10;
	localparam int STAT_W   = 2;
	localparam int CFG_W    = 11;
	localparam int RING_RST = 1024;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH  = 3'd0,
		OP_POP   = 3'd1,
		OP_PEEK  = 3'd2,
		OP_SKIP  = 3'd3,
		OP_CLEAR = 3'd4
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 2'd0,
		ST_SHORT     = 2'd1,
		ST_FULL      = 2'd2,
		ST_OVERBURST = 2'd3
	} status_t;

	typedef enum logic {
		S_IDLE  = 1'b0,
		S_BURST = 1'b1
	} fsm_t;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [DATA_W-1:0] data;
		logic [CNT_W-1:0]  cnt;
	} in_item_t;

	typedef struct packed {
		logic [DATA_W-1:0] data;
		logic              last;
		status_t           status;
		logic [USED_W-1:0] used;
	} result_t;

endpackage

@@ sv/byte_ring_fifo.sv @@
// Byte ring FIFO. Each input item is one operation (push, pop, peek, skip,
// clear) and gives one result item, or count result items for a good pop or
// peek with tlast on the final one; every result carries a status and the
// occupancy after the operation. The ring holds at most ring_length - 1 bytes;
// writing ring_length (clamped to 2..DEPTH) empties the ring. Push, skip, clear
// and rejected requests leave the block idle, so while the output is not stalled
// a push can be accepted every cycle and a pop or peek of count bytes reads the
// byte store through its single read port, one byte per cycle, taking no new
// request until its last byte is loaded. No clearing pass is needed after reset.
module byte_ring_fifo #(
	parameter int DEPTH     = bfifo_pkg::DEPTH_DEF,
	parameter int MAX_BURST = bfifo_pkg::MAX_BURST_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [15:0]                  s_tdata,  // data_in[7:0], count[12:8]
	input  logic [bfifo_pkg::OP_W-1:0]   s_tuser,  // operation[2:0]
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [23:0]                  m_tdata,  // data_out[7:0], used_count[17:8]
	output logic [bfifo_pkg::STAT_W-1:0] m_tuser,  // status[1:0]
	output logic                         m_tlast,
	input  logic                         cfg_we,
	input  logic [bfifo_pkg::CFG_W-1:0]  cfg_wdata
);

	localparam int LW      = $clog2(DEPTH + 1);
	localparam int CW      = (LW > bfifo_pkg::CFG_W) ? LW : bfifo_pkg::CFG_W;
	localparam int RST_LEN = (DEPTH < bfifo_pkg::RING_RST) ? DEPTH : bfifo_pkg::RING_RST;

	logic [LW-1:0]      len_q, len_d;
	logic [CW-1:0]      wr_wide;
	bfifo_pkg::in_item_t item;
	bfifo_pkg::result_t  result;

	// ring length clamped to 2..DEPTH
	assign wr_wide = CW'(cfg_wdata);
	always_comb begin
		priority if (wr_wide < CW'(2)) begin
			len_d = LW'(2);
		end else if (wr_wide > CW'(DEPTH)) begin
			len_d = LW'(DEPTH);
		end else begin
			len_d = LW'(wr_wide);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LW'(RST_LEN);
		end else if (cfg_we) begin
			len_q <= len_d;
		end
	end

	assign item.op   = s_tuser;
	assign item.data = s_tdata[7:0];
	assign item.cnt  = s_tdata[12:8];

	bfifo_ctrl #(.DEPTH(DEPTH), .MAX_BURST(MAX_BURST)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.len       (len_q),
		.cfg_clear (cfg_we),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.item      (item),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.result    (result)
	);

	assign m_tdata = {6'd0, result.used, result.data};
	assign m_tuser = result.status;
	assign m_tlast = result.last;

endmodule

@@ sv/bfifo_mem.sv @@
module bfifo_mem #(
	parameter int DEPTH = bfifo_pkg::DEPTH_DEF,
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [PW-1:0]                 waddr,
	input  logic [bfifo_pkg::DATA_W-1:0]  wdata,
	input  logic                          re,
	input  logic [PW-1:0]                 raddr,
	output logic [bfifo_pkg::DATA_W-1:0]  rdata
);

	logic [bfifo_pkg::DATA_W-1:0] store_q [DEPTH];
	logic [bfifo_pkg::DATA_W-1:0] rdata_q;

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (we) begin
			store_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= store_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ sv/bfifo_ctrl.sv @@
module bfifo_ctrl #(
	parameter int DEPTH     = bfifo_pkg::DEPTH_DEF,
	parameter int MAX_BURST = bfifo_pkg::MAX_BURST_DEF,
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int LW = $clog2(DEPTH + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [LW-1:0]       len,
	input  logic                cfg_clear,
	input  logic                in_valid,
	output logic                in_ready,
	input  bfifo_pkg::in_item_t item,
	output logic                out_valid,
	input  logic                out_ready,
	output bfifo_pkg::result_t  result
);

	localparam int CW = bfifo_pkg::CNT_W;

	bfifo_pkg::fsm_t    state_q, state_d;
	logic [PW-1:0]      rp_q, wp_q, addr_q;
	logic [CW-1:0]      left_q, rem_q;
	logic               pend_q;
	logic [bfifo_pkg::USED_W-1:0] bused_q;
	bfifo_pkg::result_t out_q;
	logic               out_vld_q;

	logic [LW-1:0]      used, used_after, len_m1;
	logic [LW:0]        used_wrap, rd_sum;
	logic [PW-1:0]      rp_adv, wp_inc, addr_inc;
	logic               full, cnt_bad, cnt_short;
	logic               drain, out_free, idle, acc, load, issue;
	logic               push_ok, adv_rd, clr, start_burst;
	bfifo_pkg::result_t res_single;
	logic [bfifo_pkg::DATA_W-1:0] rdata;

	bfifo_mem #(.DEPTH(DEPTH)) u_mem (
		.clk   (clk),
		.we    (acc & push_ok),
		.waddr (wp_q),
		.wdata (item.data),
		.re    (issue),
		.raddr (addr_q),
		.rdata (rdata)
	);

	// occupancy from the pointers, both always below len
	assign used_wrap = (LW+1)'(wp_q) + (LW+1)'(len) - (LW+1)'(rp_q);
	assign used      = (wp_q >= rp_q) ? LW'(wp_q) - LW'(rp_q) : LW'(used_wrap);
	assign len_m1    = len - LW'(1);
	assign full      = (used == len_m1);
	assign cnt_bad   = (item.cnt == '0) || (32'(item.cnt) > 32'(MAX_BURST));
	assign cnt_short = 32'(item.cnt) > 32'(used);

	assign rd_sum   = (LW+1)'(rp_q) + (LW+1)'(item.cnt);
	assign rp_adv   = (rd_sum >= (LW+1)'(len)) ? PW'(rd_sum - (LW+1)'(len)) : PW'(rd_sum);
	assign wp_inc   = (wp_q == PW'(len_m1)) ? '0 : wp_q + PW'(1);
	assign addr_inc = (addr_q == PW'(len_m1)) ? '0 : addr_q + PW'(1);

	assign drain    = out_vld_q & out_ready;
	assign out_free = ~out_vld_q | drain;
	assign idle     = (state_q == bfifo_pkg::S_IDLE);
	assign in_ready = idle & out_free;
	assign acc      = in_valid & in_ready;
	assign load     = pend_q & out_free;
	assign issue    = ~idle & (left_q != '0) & (~pend_q | load);

	always_comb begin
		used_after  = used;
		push_ok     = 1'b0;
		adv_rd      = 1'b0;
		clr         = 1'b0;
		start_burst = 1'b0;
		res_single.data   = '0;
		res_single.last   = 1'b1;
		res_single.status = bfifo_pkg::ST_OK;
		unique case (item.op)
			bfifo_pkg::OP_PUSH: begin
				if (full) begin
					res_single.status = bfifo_pkg::ST_FULL;
				end else begin
					push_ok    = 1'b1;
					used_after = used + LW'(1);
				end
			end
			bfifo_pkg::OP_POP, bfifo_pkg::OP_PEEK, bfifo_pkg::OP_SKIP: begin
				if (cnt_bad) begin
					res_single.status = bfifo_pkg::ST_OVERBURST;
				end else if (cnt_short) begin
					res_single.status = bfifo_pkg::ST_SHORT;
				end else begin
					if (item.op != bfifo_pkg::OP_SKIP) begin
						start_burst = 1'b1;
					end
					if (item.op != bfifo_pkg::OP_PEEK) begin
						adv_rd     = 1'b1;
						used_after = used - LW'(item.cnt);
					end
				end
			end
			bfifo_pkg::OP_CLEAR: begin
				clr        = 1'b1;
				used_after = '0;
			end
			default: begin
			end
		endcase
		res_single.used = bfifo_pkg::USED_W'(used_after);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bfifo_pkg::S_IDLE: begin
				if (acc && start_burst) begin
					state_d = bfifo_pkg::S_BURST;
				end
			end
			bfifo_pkg::S_BURST: begin
				if (load && rem_q == CW'(1)) begin
					state_d = bfifo_pkg::S_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= bfifo_pkg::S_IDLE;
			rp_q      <= '0;
			wp_q      <= '0;
			left_q    <= '0;
			rem_q     <= '0;
			pend_q    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_clear || (acc && clr)) begin
				rp_q <= '0;
				wp_q <= '0;
			end else if (acc) begin
				if (push_ok) begin
					wp_q <= wp_inc;
				end
				if (adv_rd) begin
					rp_q <= rp_adv;
				end
			end
			if (acc && start_burst) begin
				left_q <= item.cnt;
				rem_q  <= item.cnt;
			end else begin
				if (issue) begin
					left_q <= left_q - CW'(1);
				end
				if (load) begin
					rem_q <= rem_q - CW'(1);
				end
			end
			if (issue) begin
				pend_q <= 1'b1;
			end else if (load) begin
				pend_q <= 1'b0;
			end
			// a pop or peek gives only its burst bytes, no result at accept
			if ((acc && !start_burst) || load) begin
				out_vld_q <= 1'b1;
			end else if (drain) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// burst bookkeeping and output payload
	always_ff @(posedge clk) begin
		if (acc && start_burst) begin
			addr_q  <= rp_q;
			bused_q <= res_single.used;
		end else if (issue) begin
			addr_q <= addr_inc;
		end
		if (acc) begin
			out_q <= res_single;
		end else if (load) begin
			out_q.data   <= rdata;
			out_q.last   <= (rem_q == CW'(1));
			out_q.status <= bfifo_pkg::ST_OK;
			out_q.used   <= bused_q;
		end
	end

	assign out_valid = out_vld_q;
	assign result    = out_q;

`ifndef SYNTHESIS
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(LW'(rp_q) < len) && (LW'(wp_q) < len))
		else $error("pointer outside ring");

	a_burst_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bfifo_pkg::S_BURST) |-> (32'(rem_q) == 32'(left_q) + 32'(pend_q)))
		else $error("burst byte count mismatch");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		idle |-> (!pend_q && left_q == '0))
		else $error("read in flight while idle");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(load && rem_q == CW'(1)) |=> (idle && out_vld_q && out_q.last))
		else $error("burst did not end on last byte");
`endif

endmodule

@@ tb/sv/byte_ring_fifo_check.sv @@
`timescale 1ns / 100ps

module byte_ring_fifo_check #(
	parameter int DEPTH     = bfifo_pkg::DEPTH_DEF,
	parameter int MAX_BURST = bfifo_pkg::MAX_BURST_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	input  logic                         s_tready,
	input  logic [15:0]                  s_tdata,  // data_in[7:0], count[12:8]
	input  logic [bfifo_pkg::OP_W-1:0]   s_tuser,  // operation[2:0]
	input  logic                         m_tvalid,
	input  logic                         m_tready,
	input  logic [23:0]                  m_tdata,  // data_out[7:0], used_count[17:8]
	input  logic [bfifo_pkg::STAT_W-1:0] m_tuser,  // status[1:0]
	input  logic                         m_tlast,
	input  logic                         cfg_we,
	input  logic [bfifo_pkg::CFG_W-1:0]  cfg_wdata,
	output int                           fail_count,
	output int                           pending,
	output int                           ops_seen,
	output int                           results_seen
);
	import bfifo_pkg::*;

	logic [DATA_W-1:0] byte_store [DEPTH];
	int unsigned       rd_ptr = 0;
	int unsigned       wr_ptr = 0;
	logic [CFG_W-1:0]  ring_length = CFG_W'(RING_RST);
	result_t           due_results [$];
	result_t           want;

	initial begin
		fail_count   = 0;
		pending      = 0;
		ops_seen     = 0;
		results_seen = 0;
	end

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		fail_count++;
	endtask

	function automatic int unsigned ring_span();
		int unsigned span;
		span = ring_length;
		if (span < 2) span = 2;
		if (span > DEPTH) span = DEPTH;
		return span;
	endfunction

	function automatic void add_result(input logic [DATA_W-1:0] d, input logic last,
			input status_t st, input int unsigned used);
		result_t r;
		r.data   = d;
		r.last   = last;
		r.status = st;
		r.used   = USED_W'(used);
		due_results.push_back(r);
	endfunction

	function automatic void apply_ring_op(input logic [OP_W-1:0] op,
			input logic [DATA_W-1:0] din, input logic [CNT_W-1:0] cnt);
		int unsigned span;
		int unsigned used;
		int unsigned n;
		int unsigned after;
		span = ring_span();
		used = (wr_ptr + span - rd_ptr) % span;
		n = cnt;
		rd_ptr = rd_ptr % span;
		wr_ptr = wr_ptr % span;
		case (op)
			OP_PUSH: begin
				if (used >= span - 1) begin
					add_result('0, 1'b1, ST_FULL, used);
				end else begin
					byte_store[wr_ptr] = din;
					wr_ptr = (wr_ptr + 1) % span;
					add_result('0, 1'b1, ST_OK, used + 1);
				end
			end
			OP_POP, OP_PEEK, OP_SKIP: begin
				// burst limit is checked ahead of occupancy
				if (n == 0 || n > MAX_BURST) begin
					add_result('0, 1'b1, ST_OVERBURST, used);
				end else if (n > used) begin
					add_result('0, 1'b1, ST_SHORT, used);
				end else if (op == OP_SKIP) begin
					rd_ptr = (rd_ptr + n) % span;
					add_result('0, 1'b1, ST_OK, used - n);
				end else begin
					after = (op == OP_POP) ? used - n : used;
					for (int unsigned i = 0; i < n; i++)
						add_result(byte_store[(rd_ptr + i) % span], i + 1 == n, ST_OK, after);
					if (op == OP_POP)
						rd_ptr = (rd_ptr + n) % span;
				end
			end
			OP_CLEAR: begin
				rd_ptr = 0;
				wr_ptr = 0;
				add_result('0, 1'b1, ST_OK, 0);
			end
			default: begin
				add_result('0, 1'b1, ST_OK, used);
			end
		endcase
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			rd_ptr = 0;
			wr_ptr = 0;
			ring_length = CFG_W'(RING_RST);
			due_results.delete();
		end else begin
			if (cfg_we) begin
				ring_length = cfg_wdata;
				rd_ptr = 0;
				wr_ptr = 0;
			end
			// input first so a same-edge result can find its expectation
			if (s_tvalid && s_tready) begin
				apply_ring_op(s_tuser, s_tdata[7:0], s_tdata[12:8]);
				ops_seen++;
			end
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (due_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result data=%0h used=%0d status=%0d",
						m_tdata[7:0], m_tdata[17:8], m_tuser));
				end else begin
					want = due_results.pop_front();
					if (m_tdata[7:0] !== want.data)
						report_mismatch($sformatf("data_out %0h, expected %0h",
							m_tdata[7:0], want.data));
					if (m_tlast !== want.last)
						report_mismatch($sformatf("last %0b, expected %0b", m_tlast, want.last));
					if (m_tuser !== want.status)
						report_mismatch($sformatf("status %0d, expected %0d",
							m_tuser, want.status));
					if (m_tdata[17:8] !== want.used)
						report_mismatch($sformatf("used_count %0d, expected %0d",
							m_tdata[17:8], want.used));
				end
			end
		end
		pending = due_results.size();
	end

endmodule

@@ tb/sv/byte_ring_fifo_tb.sv @@
`timescale 1ns / 100ps

module byte_ring_fifo_tb;
	import bfifo_pkg::*;

	localparam int              STUCK_LIMIT  = 2000;
	localparam int              RANDOM_OPS   = 220;
	localparam logic [OP_W-1:0] OP_SPARE_LO  = 3'd5;
	localparam logic [OP_W-1:0] OP_SPARE_HI  = 3'd7;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              s_tvalid  = 1'b0;
	logic              s_tready;
	logic [15:0]       s_tdata   = '0;  // data_in[7:0], count[12:8]
	logic [OP_W-1:0]   s_tuser   = '0;  // operation[2:0]
	logic              m_tvalid;
	logic              m_tready  = 1'b0;
	logic [23:0]       m_tdata;         // data_out[7:0], used_count[17:8]
	logic [STAT_W-1:0] m_tuser;         // status[1:0]
	logic              m_tlast;
	logic              cfg_we    = 1'b0;
	logic [CFG_W-1:0]  cfg_wdata = '0;

	int fail_count;
	int pending;
	int ops_seen;
	int results_seen;

	bit tx_steady = 1'b0;
	bit rx_steady = 1'b0;
	int rx_stall  = 0;
	int ops_sent  = 0;
	int ring_writes = 0;
	int stuck_cycles = 0;

	logic [CFG_W-1:0] ring_settings [10] = '{11'd0, 11'd1024, 11'd2, 11'd3, 11'd17,
		11'd2047, 11'd300, 11'd1, 11'd7, 11'd1024};

	always #4 clk = ~clk;

	byte_ring_fifo dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	byte_ring_fifo_check check (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.fail_count  (fail_count),
		.pending     (pending),
		.ops_seen    (ops_seen),
		.results_seen(results_seen)
	);

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 96) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [CNT_W-1:0] pick_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 4) return '0;
		if (r < 10) return CNT_W'($urandom_range(MAX_BURST_DEF + 1, 31));
		if (r < 70) return CNT_W'($urandom_range(1, 4));
		return CNT_W'($urandom_range(1, MAX_BURST_DEF));
	endfunction

	always @(negedge clk) begin
		if (rx_stall > 0) begin
			m_tready <= 1'b0;
			rx_stall--;
		end else begin
			m_tready <= 1'b1;
			if (!rx_steady && $urandom_range(0, 3) == 0)
				rx_stall = gap_len();
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stuck_cycles = 0;
		else
			stuck_cycles++;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("watchdog: no item moved for %0d cycles, %0d results outstanding",
				STUCK_LIMIT, pending);
			$display("byte_ring_fifo regression: fail");
			$finish;
		end
	end

	// called at a falling edge, returns at the falling edge after the handshake
	task automatic send_op(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] din,
			input logic [CNT_W-1:0] cnt);
		int gap;
		gap = tx_steady ? 0 : gap_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {3'b000, cnt, din};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
		ops_sent++;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		wait (pending == 0);
		@(negedge clk);
	endtask

	task automatic write_ring_length(input logic [CFG_W-1:0] value);
		wait_drained();
		// every result has been taken here, so no pop is still reading
		repeat (4) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		ring_writes++;
	endtask

	task automatic send_random_op();
		int r;
		logic [OP_W-1:0] op;
		r = $urandom_range(0, 99);
		if (r < 45)      op = OP_PUSH;
		else if (r < 63) op = OP_POP;
		else if (r < 75) op = OP_PEEK;
		else if (r < 88) op = OP_SKIP;
		else if (r < 94) op = OP_CLEAR;
		else             op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
		send_op(op, DATA_W'($urandom), pick_count());
	endtask

	// a run of pushes followed by one pop, peek or skip of the same length
	task automatic send_packet();
		int len;
		int r;
		logic [OP_W-1:0] op;
		len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, MAX_BURST_DEF)
			: $urandom_range(1, 5);
		for (int i = 0; i < len; i++)
			send_op(OP_PUSH, DATA_W'($urandom), CNT_W'($urandom));
		r = $urandom_range(0, 9);
		op = (r < 6) ? OP_POP : (r < 8) ? OP_PEEK : OP_SKIP;
		send_op(op, DATA_W'($urandom), CNT_W'(len));
	endtask

	initial begin
		int goal;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: rejected and undefined operations on an empty ring at the reset length, then pushes, bursts and a clear
		send_op(OP_POP, 8'h00, 5'd1);
		send_op(OP_PEEK, 8'hff, 5'd0);
		send_op(OP_SKIP, 8'h00, 5'd31);
		send_op(OP_SPARE_HI, 8'h5a, 5'd3);
		for (int i = 0; i < MAX_BURST_DEF; i++)
			send_op(OP_PUSH, (i == 0) ? 8'h00 : (i == 1) ? 8'hff : DATA_W'($urandom),
				CNT_W'($urandom));
		send_op(OP_PEEK, 8'h00, 5'd16);
		send_op(OP_POP, 8'h00, 5'd17);
		send_op(OP_SKIP, 8'h00, 5'd3);
		send_op(OP_POP, 8'h00, 5'd16);
		send_op(OP_POP, 8'h00, 5'd13);
		send_op(OP_CLEAR, 8'h00, 5'd0);

		goal = ops_sent;
		foreach (ring_settings[p]) begin
			write_ring_length(ring_settings[p]);
			tx_steady = (p == 3);
			rx_steady = (p == 5);
			goal += RANDOM_OPS / 10;
			while (ops_sent < goal) begin
				if ($urandom_range(0, 9) < 3)
					send_packet();
				else
					send_random_op();
				// hold the sender at most once until the output side has caught up
				if (p == 4 && ops_sent == goal - 10)
					wait_drained();
			end
		end

		wait_drained();
		repeat (24) @(posedge clk);
		$display("run covered %0d operations and %0d result items", ops_seen, results_seen);
		$display("over %0d ring length writes plus the reset length", ring_writes);
		if (fail_count == 0)
			$display("byte_ring_fifo regression: pass");
		else
			$display("byte_ring_fifo regression: fail");
		$finish;
	end

endmodule
